>>> hw/rtl/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types, constants and helpers for the depth-first search block.
// ----------------------------------------------------------------------------
package gdfs_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VERT_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	typedef logic [VERT_W-1:0]       vert_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [MAX_VERTICES-1:0] row_t;

	localparam cnt_t CNT_RESET = cnt_t'(MAX_VERTICES);
	localparam cnt_t CNT_MIN   = cnt_t'(2);

	typedef enum logic {
		KIND_EDGE   = 1'b0,
		KIND_SEARCH = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t kind;
		vert_t vertex_a;
		vert_t vertex_b;
	} item_t;

	typedef struct packed {
		vert_t visited_vertex;
		logic  found;
		logic  rejected;
		logic  last;
	} result_t;

	// vertex count actually in use
	function automatic cnt_t clamp_count(cnt_t c);
		cnt_t r;
		r = c;
		if (c < CNT_MIN) r = CNT_MIN;
		if (c > cnt_t'(MAX_VERTICES)) r = cnt_t'(MAX_VERTICES);
		return r;
	endfunction

	// bits below n set
	function automatic row_t lower_mask(cnt_t n);
		row_t m;
		for (int i = 0; i < MAX_VERTICES; i++) m[i] = (cnt_t'(i) < n);
		return m;
	endfunction

	// index of highest set bit
	function automatic vert_t top_bit(row_t v);
		vert_t idx;
		idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) if (v[i]) idx = vert_t'(i);
		return idx;
	endfunction

endpackage

>>> hw/rtl/graph_depth_first_search.sv
// ----------------------------------------------------------------------------
// graph_depth_first_search
// Directed graph in an adjacency bit matrix with depth-first search.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item while start is high and busy is low. An add-edge
//   beat with both vertices in range sets one matrix bit (read, modify,
//   write back) and keeps busy high for one cycle; others are dropped.
//   Neither gives a result. A search beat walks the graph with a stack in
//   RAM and sends one result per visited vertex on result, each marked by
//   a one-cycle result_valid strobe; the final beat has last. Out-of-range
//   or start-equal-target searches answer in the next cycle with busy low.
// Sequence:
//   A visited vertex takes a stack read (S_POP) and a matrix row read
//   (S_ROW), then S_SCAN pushes its unvisited neighbours one at a time and
//   emits its result; the start vertex skips the stack read. The matrix
//   RAM read port and the single stack write port pace the search.
// Reset:
//   Clears the control state, the vertex count register (to 32) and one
//   row-valid flag per matrix row; an unwritten row reads as zero, so no
//   clearing pass is needed. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module graph_depth_first_search
	import gdfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	input  logic    cfg_we,
	input  cnt_t    cfg_wdata,
	output logic    result_valid,
	output result_t result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_ROW,
		S_SCAN,
		S_POP
	} state_t;

	state_t  state_q;
	cnt_t    count_q;
	vert_t   cur_q;
	vert_t   target_q;
	cnt_t    depth_q;
	row_t    visited_q;
	row_t    cand_q;
	row_t    row_vld_q;
	logic    vld_s1;
	result_t result_q;
	logic    result_valid_q;

	cnt_t  n_use;
	row_t  vmask;
	logic  accept;
	logic  a_ok;
	logic  b_ok;
	cnt_t  depth_m1;
	vert_t push_v;

	vert_t adj_raddr;
	row_t  adj_rdata;
	row_t  adj_row;
	logic  adj_we;
	row_t  adj_wdata;

	logic  stk_we;
	vert_t stk_rdata;

	assign n_use    = clamp_count(count_q);
	assign vmask    = lower_mask(n_use);
	assign accept   = start && (state_q == S_IDLE);
	assign a_ok     = cnt_t'(item.vertex_a) < n_use;
	assign b_ok     = cnt_t'(item.vertex_b) < n_use;
	assign depth_m1 = depth_q - cnt_t'(1);
	assign push_v   = top_bit(cand_q);

	assign adj_raddr = (state_q == S_POP) ? stk_rdata : item.vertex_a;
	assign adj_row   = adj_rdata & {MAX_VERTICES{vld_s1}};
	assign adj_we    = (state_q == S_EDGE);
	assign adj_wdata = adj_row | (row_t'(1) << target_q);
	assign stk_we    = (state_q == S_SCAN) && (cand_q != '0);

	gdfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (cur_q),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	gdfs_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[VERT_W-1:0]),
		.wdata (push_v),
		.raddr (depth_m1[VERT_W-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= CNT_RESET;
			cur_q          <= '0;
			target_q       <= '0;
			depth_q        <= '0;
			visited_q      <= '0;
			cand_q         <= '0;
			row_vld_q      <= '0;
			vld_s1         <= 1'b0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			vld_s1         <= row_vld_q[adj_raddr];
			if (cfg_we) count_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_q    <= item.vertex_a;
						target_q <= item.vertex_b;
						if (item.kind == KIND_EDGE) begin
							if (a_ok && b_ok) state_q <= S_EDGE;
						end else if (!(a_ok && b_ok)) begin
							result_q       <= '{visited_vertex: '0, found: 1'b0,
							                    rejected: 1'b1, last: 1'b1};
							result_valid_q <= 1'b1;
						end else if (item.vertex_a == item.vertex_b) begin
							result_q       <= '{visited_vertex: item.vertex_a, found: 1'b1,
							                    rejected: 1'b0, last: 1'b1};
							result_valid_q <= 1'b1;
						end else begin
							visited_q <= row_t'(1) << item.vertex_a;
							depth_q   <= '0;
							state_q   <= S_ROW;
						end
					end
				end
				S_EDGE: begin
					row_vld_q[cur_q] <= 1'b1;
					state_q          <= S_IDLE;
				end
				S_ROW: begin
					cand_q  <= adj_row & ~visited_q & vmask;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cand_q != '0) begin
						visited_q[push_v] <= 1'b1;
						cand_q[push_v]    <= 1'b0;
						depth_q           <= depth_q + cnt_t'(1);
					end else begin
						result_q       <= '{visited_vertex: cur_q, found: 1'b0,
						                    rejected: 1'b0, last: (depth_q == '0)};
						result_valid_q <= 1'b1;
						if (depth_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							depth_q <= depth_m1;
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					cur_q <= stk_rdata;
					if (stk_rdata == target_q) begin
						result_q       <= '{visited_vertex: stk_rdata, found: 1'b1,
						                    rejected: 1'b0, last: 1'b1};
						result_valid_q <= 1'b1;
						depth_q        <= '0;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_ROW;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= cnt_t'(MAX_VERTICES))
		else $error("stack depth overflow");

	a_found_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |-> result.last)
		else $error("found result not marked last");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rejected |-> result.last && !result.found)
		else $error("malformed rejected result");

	a_edge_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.kind == KIND_EDGE |=> !result_valid)
		else $error("edge beat produced a result");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && cand_q == '0 && depth_q != '0 |=> state_q == S_POP)
		else $error("pending stack not popped");

endmodule

>>> hw/rtl/gdfs_ram.sv
// ----------------------------------------------------------------------------
// gdfs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
